// File: sv/vtnl_pkg.sv
package vtnl_pkg;

  localparam int Dim       = 128;
  localparam int Nodes     = 1024;
  localparam int CompBits  = 16;
  localparam int NodeW     = 10;
  localparam int DimW      = 7;
  localparam int DistW     = 40;
  localparam int LeafW     = 11;
  localparam int DimsW     = 8;
  localparam int CenterAw  = NodeW + DimW;

  typedef enum logic [1:0] {
    CMD_LOAD_CENTER = 2'd0,
    CMD_LOAD_RANGE  = 2'd1,
    CMD_LOAD_QUERY  = 2'd2,
    CMD_DESCEND     = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NODE_RD,
    ST_NODE_CHK,
    ST_DIST_START,
    ST_DIST_RUN,
    ST_DIST_DRAIN,
    ST_DIST_WAIT,
    ST_COMPARE,
    ST_EMIT
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load_start;   // current node from input
    logic node_rd;      // read child range of current node
    logic first_cand;   // candidate = first child
    logic next_cand;    // candidate += 1
    logic dist_clear;   // clear accumulator and dim counter
    logic dist_issue;   // issue one component read
    logic dist_acc;     // accumulate one squared difference
    logic take_best;    // update best if better or first
    logic move_best;    // current node = best child
    logic set_bad;
    logic clr_bad;
  } ctrl_t;

  // datapath status
  typedef struct packed {
    logic is_leaf;
    logic range_bad;
    logic last_dim;     // issuing final component
    logic zero_dims;
    logic last_cand;
  } stat_t;

  localparam logic [1:0] RegLeafStart = 2'd0;
  localparam logic [1:0] RegDimsInUse = 2'd1;

endpackage

// File: sv/vtnl_ctrl.sv
module vtnl_ctrl import vtnl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  out_taken_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy_o,
  output logic  out_valid_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    busy_o      = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctrl_o.load_start = 1'b1;
          ctrl_o.clr_bad    = 1'b1;
          state_d           = ST_NODE_RD;
        end
      end
      ST_NODE_RD: begin
        ctrl_o.node_rd = 1'b1;
        state_d        = ST_NODE_CHK;
      end
      ST_NODE_CHK: begin
        if (stat_i.is_leaf) begin
          state_d = ST_EMIT;
        end else if (stat_i.range_bad) begin
          ctrl_o.set_bad = 1'b1;
          state_d        = ST_EMIT;
        end else begin
          ctrl_o.first_cand = 1'b1;
          state_d           = ST_DIST_START;
        end
      end
      ST_DIST_START: begin
        ctrl_o.dist_clear = 1'b1;
        state_d = stat_i.zero_dims ? ST_COMPARE : ST_DIST_RUN;
      end
      ST_DIST_RUN: begin
        // memory reads in flight, accumulation trails behind the read and difference stages
        ctrl_o.dist_issue = 1'b1;
        ctrl_o.dist_acc   = 1'b1;
        if (stat_i.last_dim) begin
          state_d = ST_DIST_DRAIN;
        end
      end
      ST_DIST_DRAIN: begin
        ctrl_o.dist_acc = 1'b1;
        state_d         = ST_DIST_WAIT;
      end
      ST_DIST_WAIT: begin
        ctrl_o.dist_acc = 1'b1;
        state_d         = ST_COMPARE;
      end
      ST_COMPARE: begin
        ctrl_o.take_best = 1'b1;
        if (stat_i.last_cand) begin
          ctrl_o.move_best = 1'b1;
          state_d          = ST_NODE_RD;
        end else begin
          ctrl_o.next_cand = 1'b1;
          state_d          = ST_DIST_START;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_taken_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: sv/vtnl_dp.sv
module vtnl_dp import vtnl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_t               ctrl_i,
  input  logic                wr_en_i,
  input  logic [1:0]          cmd_i,
  input  logic [NodeW-1:0]    node_index_i,
  input  logic [DimW-1:0]     dim_index_i,
  input  logic [CompBits-1:0] component_i,
  input  logic [NodeW-1:0]    first_child_i,
  input  logic [NodeW-1:0]    last_child_i,
  input  logic [LeafW-1:0]    leaf_start_i,
  input  logic [DimsW-1:0]    dims_in_use_i,
  output stat_t               stat_o,
  output logic [NodeW-1:0]    leaf_index_o,
  output logic                bad_range_o
);

  logic [CompBits-1:0] center_mem [2**CenterAw];
  logic [NodeW-1:0]    first_mem  [Nodes];
  logic [NodeW-1:0]    last_mem   [Nodes];
  logic [CompBits-1:0] query_mem  [Dim];

  logic [NodeW-1:0]    cur_q, cand_q, best_q, lo_q, hi_q;
  logic [DistW-1:0]    best_dist_q, acc_q;
  logic [DimsW-1:0]    cnt_q;
  logic                bad_q, first_q;
  logic [CompBits-1:0] c_rd_q, q_rd_q;
  logic                v1_q, v2_q;
  logic [CompBits-1:0] diff_q;
  logic [DimsW-1:0]    n_dims;
  logic [2*CompBits-1:0] sq;
  logic                better;

  assign n_dims = (dims_in_use_i > DimsW'(Dim)) ? DimsW'(Dim) : dims_in_use_i;

  // squared difference and candidate compare
  assign sq     = diff_q * diff_q;
  assign better = first_q || (acc_q < best_dist_q);

  // table writes
  always_ff @(posedge clk_i) begin
    if (wr_en_i && cmd_i == CMD_LOAD_CENTER) begin
      center_mem[{node_index_i, dim_index_i}] <= component_i;
    end
    if (wr_en_i && cmd_i == CMD_LOAD_RANGE) begin
      first_mem[node_index_i] <= first_child_i;
      last_mem[node_index_i]  <= last_child_i;
    end
    if (wr_en_i && cmd_i == CMD_LOAD_QUERY) begin
      query_mem[dim_index_i] <= component_i;
    end
  end

  // child range read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.node_rd) begin
      lo_q <= first_mem[cur_q];
      hi_q <= last_mem[cur_q];
    end
  end

  // component reads, stage one
  always_ff @(posedge clk_i) begin
    c_rd_q <= center_mem[{cand_q, cnt_q[DimW-1:0]}];
    q_rd_q <= query_mem[cnt_q[DimW-1:0]];
  end

  // absolute difference, stage two
  always_ff @(posedge clk_i) begin
    diff_q <= (q_rd_q > c_rd_q) ? (q_rd_q - c_rd_q) : (c_rd_q - q_rd_q);
  end

  // pipeline valids and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0; cand_q <= '0; best_q <= '0;
      best_dist_q <= '1; acc_q <= '0; cnt_q <= '0;
      bad_q <= 1'b0; first_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.dist_issue;
      v2_q <= v1_q;
      if (ctrl_i.load_start) cur_q <= node_index_i;
      // last candidate may itself be the nearest
      if (ctrl_i.move_best)  cur_q <= better ? cand_q : best_q;
      if (ctrl_i.clr_bad)    bad_q <= 1'b0;
      if (ctrl_i.set_bad)    bad_q <= 1'b1;
      if (ctrl_i.first_cand) begin
        cand_q  <= lo_q;
        first_q <= 1'b1;
      end
      if (ctrl_i.next_cand)  cand_q <= cand_q + NodeW'(1);
      if (ctrl_i.dist_clear) begin
        acc_q <= '0;
        cnt_q <= '0;
      end
      if (ctrl_i.dist_issue) cnt_q <= cnt_q + DimsW'(1);
      if (ctrl_i.dist_acc && v2_q) begin
        acc_q <= acc_q + DistW'(sq);
      end
      // strict less keeps lowest index on ties
      if (ctrl_i.take_best) begin
        first_q <= 1'b0;
        if (better) begin
          best_dist_q <= acc_q;
          best_q      <= cand_q;
        end
      end
    end
  end

  // status
  always_comb begin
    stat_o.is_leaf   = {1'b0, cur_q} >= leaf_start_i;
    stat_o.range_bad = (hi_q < lo_q) || (lo_q <= cur_q);
    stat_o.last_dim  = (cnt_q + DimsW'(1)) == n_dims;
    stat_o.zero_dims = (n_dims == '0);
    stat_o.last_cand = (cand_q == hi_q);
  end

  assign leaf_index_o = cur_q;
  assign bad_range_o  = bad_q;

endmodule

// File: sv/vocab_tree_nearest_leaf_core.sv
// operation: loads write the tables on transfer; a descent reads each level's child
//   range and sweeps the components of every child before moving to the nearest
// throughput: one load per cycle while no descent is busy; one descent at a time,
//   set by the single center memory read port sweeping one component per cycle
// reset: rst_ni async active low; registers return to defaults, tables undefined
module vocab_tree_nearest_leaf_core import vtnl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          cmd_i,
  input  logic [NodeW-1:0]    node_index_i,
  input  logic [DimW-1:0]     dim_index_i,
  input  logic [CompBits-1:0] component_i,
  input  logic [NodeW-1:0]    first_child_i,
  input  logic [NodeW-1:0]    last_child_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [NodeW-1:0]    leaf_index_o,
  output logic                bad_range_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [LeafW-1:0] leaf_start_q;
  logic [DimsW-1:0] dims_q;
  ctrl_t            ctrl;
  stat_t            stat;
  logic             busy, in_xfer, start;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_start_q <= LeafW'(1);
      dims_q       <= DimsW'(128);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegDimsInUse[0]) dims_q <= pwdata[DimsW-1:0];
      else if (paddr[2] == RegLeafStart[0]) leaf_start_q <= pwdata[LeafW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegDimsInUse[0]) prdata = 32'(dims_q);
    else prdata = 32'(leaf_start_q);
  end

  // input transfer
  assign in_stall_o = busy;
  assign in_xfer    = in_valid_i && !busy;
  assign start      = in_xfer && (cmd_i == CMD_DESCEND);

  vtnl_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i     (start),
    .out_taken_i (!out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl),
    .busy_o      (busy),
    .out_valid_o (out_valid_o)
  );

  vtnl_dp u_dp (
    .clk_i, .rst_ni,
    .ctrl_i        (ctrl),
    .wr_en_i       (in_xfer),
    .cmd_i, .node_index_i, .dim_index_i, .component_i,
    .first_child_i, .last_child_i,
    .leaf_start_i  (leaf_start_q),
    .dims_in_use_i (dims_q),
    .stat_o        (stat),
    .leaf_index_o, .bad_range_o
  );

endmodule

// File: sv/vtnl_checker.sv
module vtnl_checker import vtnl_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [NodeW-1:0] leaf_index_o,
  input logic             bad_range_o
);

  // held result does not change while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(leaf_index_o)
      && $stable(bad_range_o))
    else $error("result changed while stalled");

  // no input taken while a result waits
  a_stall_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted with result pending");

  // a result is dropped once it has transferred
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("result repeated");

  // no result in the cycle after an input transfer
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result right after input transfer");

  // no result straight after reset
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o || !rst_ni)
    else $error("result after reset");

endmodule

bind vocab_tree_nearest_leaf_core vtnl_checker u_vtnl_checker (.*);
